// File: design/lspt_pkg.sv
// ----------------------------------------------------------------------------
// Line sensor position tracker package
// Shared types, constants and register indexes for the tracker.
// ----------------------------------------------------------------------------
package lspt_pkg;

  localparam int unsigned SensorCount = 4;
  localparam int unsigned SampleW     = 10;
  localparam int unsigned QueueDepth  = 2;

  localparam logic [9:0] NoiseFloorRst    = 10'd50;
  localparam logic [9:0] LineThresholdRst = 10'd200;
  localparam logic [9:0] HighLevelRst     = 10'd700;
  localparam logic [9:0] LowLevelRst      = 10'd300;

  // Register indexes of the configuration port.
  localparam logic [1:0] RegNoiseFloor    = 2'd0;
  localparam logic [1:0] RegLineThreshold = 2'd1;
  localparam logic [1:0] RegHighLevel     = 2'd2;
  localparam logic [1:0] RegLowLevel      = 2'd3;

  // Item modes.
  localparam logic [1:0] ModeMeasure = 2'd0;
  localparam logic [1:0] ModeWhite   = 2'd1;
  localparam logic [1:0] ModeBlack   = 2'd2;
  localparam logic [1:0] ModeNone    = 2'd3;

  // Surface codes.
  localparam logic [1:0] SurfAllWhite  = 2'd0;
  localparam logic [1:0] SurfAllBlack  = 2'd1;
  localparam logic [1:0] SurfWhiteLine = 2'd2;
  localparam logic [1:0] SurfBlackLine = 2'd3;

  typedef enum logic [1:0] {
    KindMeasure,
    KindWhite,
    KindBlack,
    KindNone
  } kind_e;

  // One classified request as it waits in the queue.
  typedef struct packed {
    kind_e                    kind;
    logic                     restart;
    logic [3:0][SampleW-1:0]  samples;
  } req_t;

  typedef enum logic [2:0] {
    StIdle,
    StScale,
    StClassify,
    StCentroid,
    StPosition,
    StOut
  } state_e;

  // Divider interface between back end and divider.
  typedef struct packed {
    logic        start;
    logic [20:0] dividend;
    logic [20:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [20:0] quotient;
  } div_rsp_t;

endpackage

// File: design/line_sensor_position_tracker_top.sv
// ----------------------------------------------------------------------------
// Line sensor position tracker top level
// Four-sensor line tracker with calibration and weighted centroid.
// ----------------------------------------------------------------------------
// A calibrate request passes straight from the idle state to the output state. A
// measure request runs up to four scale divisions and at most one centroid
// division through one shared divider that produces a quotient bit per cycle.
// A two-entry request queue lets the input side run ahead while the back end
// works.
module line_sensor_position_tracker_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] mode_i,
  input  logic       restart_i,
  input  logic [9:0] sample_0_i,
  input  logic [9:0] sample_1_i,
  input  logic [9:0] sample_2_i,
  input  logic [9:0] sample_3_i,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index_i,
  input  logic [9:0] cfg_data_i,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] surface_status_o,
  output logic [7:0] line_error_o,
  output logic       line_seen_o
);

  logic           q_valid, q_pop;
  lspt_pkg::req_t q_req;
  logic [9:0]     noise_floor_q, line_threshold_q, high_level_q, low_level_q;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_floor_q    <= lspt_pkg::NoiseFloorRst;
      line_threshold_q <= lspt_pkg::LineThresholdRst;
      high_level_q     <= lspt_pkg::HighLevelRst;
      low_level_q      <= lspt_pkg::LowLevelRst;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_i)
        lspt_pkg::RegNoiseFloor:    noise_floor_q    <= cfg_data_i;
        lspt_pkg::RegLineThreshold: line_threshold_q <= cfg_data_i;
        lspt_pkg::RegHighLevel:     high_level_q     <= cfg_data_i;
        lspt_pkg::RegLowLevel:      low_level_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lspt_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode_i    (mode_i),
    .restart_i (restart_i),
    .sample_0_i(sample_0_i),
    .sample_1_i(sample_1_i),
    .sample_2_i(sample_2_i),
    .sample_3_i(sample_3_i),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop),
    .q_req_o   (q_req)
  );

  lspt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_pop_o         (q_pop),
    .q_req_i         (q_req),
    .noise_floor_i   (noise_floor_q),
    .line_threshold_i(line_threshold_q),
    .high_level_i    (high_level_q),
    .low_level_i     (low_level_q),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .surface_status_o(surface_status_o),
    .line_error_o    (line_error_o),
    .line_seen_o     (line_seen_o)
  );

endmodule

// File: design/lspt_front.sv
// ----------------------------------------------------------------------------
// Line sensor position tracker front end
// Accepts input requests, classifies the mode and queues them.
// ----------------------------------------------------------------------------
module lspt_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      mode_i,
  input  logic            restart_i,
  input  logic [9:0]      sample_0_i,
  input  logic [9:0]      sample_1_i,
  input  logic [9:0]      sample_2_i,
  input  logic [9:0]      sample_3_i,
  output logic            q_valid_o,
  input  logic            q_pop_i,
  output lspt_pkg::req_t  q_req_o
);

  lspt_pkg::req_t q_mem_q [lspt_pkg::QueueDepth];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  lspt_pkg::req_t new_req;
  logic           push;

  // Classify the mode of the incoming request.
  always_comb begin
    new_req.restart = restart_i;
    new_req.samples = {sample_3_i, sample_2_i, sample_1_i, sample_0_i};
    case (mode_i)
      lspt_pkg::ModeMeasure: new_req.kind = lspt_pkg::KindMeasure;
      lspt_pkg::ModeWhite:   new_req.kind = lspt_pkg::KindWhite;
      lspt_pkg::ModeBlack:   new_req.kind = lspt_pkg::KindBlack;
      default:               new_req.kind = lspt_pkg::KindNone;
    endcase
  end

  assign in_ready  = (count_q != 2'd2);
  assign push      = in_valid && in_ready;
  assign q_valid_o = (count_q != 2'd0);
  assign q_req_o   = q_mem_q[rd_ptr_q];

  // Queue pointers.
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ (q_pop_i && q_valid_o);
    count_d  = count_q + {1'b0, push} - {1'b0, q_pop_i && q_valid_o};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= new_req;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd2) |-> !in_ready)
    else $error("ready while queue full");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !(q_pop_i && q_valid_o)) |=> (count_q == $past(count_q) + 2'd1))
    else $error("push lost");

endmodule

// File: design/lspt_div.sv
// ----------------------------------------------------------------------------
// Line sensor position tracker divider
// Shared restoring divider, one quotient bit per cycle, 21-bit operands.
// ----------------------------------------------------------------------------
module lspt_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lspt_pkg::div_req_t  req_i,
  output lspt_pkg::div_rsp_t  rsp_o
);

  logic [20:0] quo_q, quo_d;
  logic [21:0] rem_q, rem_d;
  logic [20:0] dvs_q, dvs_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [21:0] trial;

  // One restoring step per cycle.
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[20:0], quo_q[20]} - {1'b0, dvs_q};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = 5'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[21]) begin
        rem_d = trial;
        quo_d = {quo_q[19:0], 1'b1};
      end else begin
        rem_d = {rem_q[20:0], quo_q[20]};
        quo_d = {quo_q[19:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd20) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("divider done while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q)
    else $error("divider failed to start");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !rem_q[21])
    else $error("remainder went negative");

endmodule

// File: design/lspt_back.sv
// ----------------------------------------------------------------------------
// Line sensor position tracker back end
// Executes queued requests: calibration merge, scaling, classification
// and the weighted centroid.
// ----------------------------------------------------------------------------
module lspt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_pop_o,
  input  lspt_pkg::req_t  q_req_i,
  input  logic [9:0]      noise_floor_i,
  input  logic [9:0]      line_threshold_i,
  input  logic [9:0]      high_level_i,
  input  logic [9:0]      low_level_i,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      surface_status_o,
  output logic [7:0]      line_error_o,
  output logic            line_seen_o
);

  lspt_pkg::state_e   state_q, state_d;
  lspt_pkg::div_req_t div_req;
  lspt_pkg::div_rsp_t div_rsp;

  logic [3:0][9:0] white_q;
  logic [3:0][9:0] black_q;
  logic [3:0][9:0] samp_q;
  logic [7:0]      last_pos_q;
  logic [3:0][9:0] val_q;
  logic [1:0]      idx_q;
  logic            div_busy_q;
  logic [1:0]      status_q;
  logic            seen_q;
  logic [11:0]     sum_q;
  logic [12:0]     wsum_q;
  logic [7:0]      err_q;
  logic            ovalid_q;
  logic [1:0]      ostat_q;
  logic [7:0]      oerr_q;
  logic            oseen_q;

  logic            take;
  logic [9:0]      w_cur, b_cur, raw_cur;
  logic            lvl_ok;
  logic [2:0]      n_high, n_low, n_mid;
  logic [1:0]      status_c;
  logic [3:0][9:0] v_inv;
  logic            seen_c;
  logic [11:0]     sum_c;
  logic [12:0]     wsum_c;
  logic [7:0]      pos_fb;

  lspt_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign take    = (state_q == lspt_pkg::StIdle) && q_valid_i;
  assign q_pop_o = take;
  assign w_cur   = white_q[idx_q];
  assign b_cur   = black_q[idx_q];
  assign raw_cur = samp_q[idx_q];
  assign lvl_ok  = w_cur > b_cur;

  // Divider requests: per-sensor scale, then the centroid.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = 21'(raw_cur) * 21'd1000;
    div_req.divisor  = 21'(w_cur - b_cur);
    if (state_q == lspt_pkg::StScale && !div_busy_q && lvl_ok) begin
      div_req.start = 1'b1;
    end
    if (state_q == lspt_pkg::StPosition) begin
      div_req.start    = !div_busy_q;
      div_req.dividend = 21'(wsum_q) * 21'd200;
      div_req.divisor  = 21'(sum_q) * 21'd3;
    end
  end

  // Sensor counting for classification.
  always_comb begin
    n_high = '0;
    n_low  = '0;
    n_mid  = '0;
    for (int i = 0; i < lspt_pkg::SensorCount; i++) begin
      if (val_q[i] >= high_level_i) n_high = n_high + 3'd1;
      else if (val_q[i] <= low_level_i) n_low = n_low + 3'd1;
      else n_mid = n_mid + 3'd1;
    end
    if (n_low == 3'd4) status_c = lspt_pkg::SurfAllWhite;
    else if (n_high == 3'd4) status_c = lspt_pkg::SurfAllBlack;
    else if (n_high >= n_mid || n_high > n_low) status_c = lspt_pkg::SurfWhiteLine;
    else status_c = lspt_pkg::SurfBlackLine;
  end

  // Inversion, line detection and gated sums.
  always_comb begin
    seen_c = 1'b0;
    sum_c  = '0;
    wsum_c = '0;
    for (int i = 0; i < lspt_pkg::SensorCount; i++) begin
      v_inv[i] = (status_q == lspt_pkg::SurfWhiteLine) ? 10'd1000 - val_q[i] : val_q[i];
      if (v_inv[i] > line_threshold_i) seen_c = 1'b1;
      if (v_inv[i] > noise_floor_i) begin
        sum_c  = sum_c + 12'(v_inv[i]);
        wsum_c = wsum_c + 13'(v_inv[i]) * 13'(i);
      end
    end
  end

  assign pos_fb = (last_pos_q > 8'd100) ? 8'd200 : 8'd0;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lspt_pkg::StIdle: begin
        if (take && q_req_i.kind == lspt_pkg::KindMeasure) state_d = lspt_pkg::StScale;
        else if (take) state_d = lspt_pkg::StOut;
      end
      lspt_pkg::StScale: begin
        if (idx_q == 2'd3 && (!lvl_ok || div_rsp.done)) state_d = lspt_pkg::StClassify;
      end
      lspt_pkg::StClassify: state_d = lspt_pkg::StCentroid;
      lspt_pkg::StCentroid: begin
        state_d = (seen_c && sum_c != 12'd0) ? lspt_pkg::StPosition : lspt_pkg::StOut;
      end
      lspt_pkg::StPosition: if (div_rsp.done) state_d = lspt_pkg::StOut;
      lspt_pkg::StOut: if (!ovalid_q || out_ready) state_d = lspt_pkg::StIdle;
      default: state_d = lspt_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lspt_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath and calibration state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_q    <= '0;
      black_q    <= {4{10'd1023}};
      samp_q     <= '0;
      last_pos_q <= '0;
      idx_q      <= '0;
      div_busy_q <= 1'b0;
      ovalid_q   <= 1'b0;
      ostat_q    <= '0;
      oerr_q     <= '0;
      oseen_q    <= 1'b0;
      status_q   <= '0;
      seen_q     <= 1'b0;
      sum_q      <= '0;
      wsum_q     <= '0;
      err_q      <= '0;
      val_q      <= '0;
    end else begin
      // The result register loads only when it is empty or being taken.
      if (state_q == lspt_pkg::StOut && (!ovalid_q || out_ready)) begin
        ovalid_q <= 1'b1;
        ostat_q  <= status_q;
        oerr_q   <= err_q;
        oseen_q  <= seen_q;
      end else if (out_valid && out_ready) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        lspt_pkg::StIdle: begin
          idx_q      <= '0;
          div_busy_q <= 1'b0;
          status_q   <= lspt_pkg::SurfAllWhite;
          seen_q     <= 1'b0;
          sum_q      <= '0;
          wsum_q     <= '0;
          if (take) begin
            samp_q <= q_req_i.samples;
            if (q_req_i.kind != lspt_pkg::KindMeasure) err_q <= '0;
            for (int i = 0; i < lspt_pkg::SensorCount; i++) begin
              if (q_req_i.kind == lspt_pkg::KindWhite) begin
                if (q_req_i.restart || q_req_i.samples[i] > white_q[i])
                  white_q[i] <= q_req_i.samples[i];
              end
              if (q_req_i.kind == lspt_pkg::KindBlack) begin
                if (q_req_i.restart || q_req_i.samples[i] < black_q[i])
                  black_q[i] <= q_req_i.samples[i];
              end
            end
          end
        end
        lspt_pkg::StScale: begin
          if (!lvl_ok) begin
            val_q[idx_q] <= 10'd1000;
            idx_q        <= idx_q + 2'd1;
          end else if (div_rsp.done) begin
            val_q[idx_q] <= (div_rsp.quotient >= 21'd1000) ? 10'd0 :
                            10'd1000 - div_rsp.quotient[9:0];
            idx_q        <= idx_q + 2'd1;
            div_busy_q   <= 1'b0;
          end else begin
            div_busy_q   <= 1'b1;
          end
        end
        lspt_pkg::StClassify: status_q <= status_c;
        lspt_pkg::StCentroid: begin
          seen_q <= seen_c;
          sum_q  <= sum_c;
          wsum_q <= wsum_c;
          if (!(seen_c && sum_c != 12'd0)) begin
            err_q <= pos_fb - 8'd100;
          end
        end
        lspt_pkg::StPosition: begin
          if (div_rsp.done) begin
            last_pos_q <= div_rsp.quotient[7:0];
            err_q      <= div_rsp.quotient[7:0] - 8'd100;
            div_busy_q <= 1'b0;
          end else begin
            div_busy_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid        = ovalid_q;
  assign surface_status_o = ostat_q;
  assign line_error_o     = oerr_q;
  assign line_seen_o      = oseen_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == lspt_pkg::StIdle))
    else $error("pop while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=>
      ($stable(line_error_o) && $stable(surface_status_o) && $stable(line_seen_o)))
    else $error("result changed while waiting");

endmodule
